// ===== design/adjacency_matrix_degree_scan_unit_assert.svh =====
// assertion macros for the scan unit
`ifndef ADJACENCY_MATRIX_DEGREE_SCAN_UNIT_ASSERT_SVH
`define ADJACENCY_MATRIX_DEGREE_SCAN_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AMDS_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("scan unit assertion failed");

// next-cycle implication, checked outside reset
`define AMDS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("scan unit assertion failed");

`endif

// ===== design/amds_pkg.sv =====
package amds_pkg;

    // sizing of the matrix and the cost field
    localparam int MAX_NODES  = 64;
    localparam int COST_BITS  = 16;
    localparam int COL_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);

    // fixed widths of the result fields and the config word
    localparam int NODE_W     = 7;
    localparam int MAXC_W     = 15;
    localparam int CFG_W      = 7;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((COST_BITS + 7) / 8) * 8;
    localparam int RES_W       = 5 * NODE_W + MAXC_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    // result fields, lowest field in the lowest bits
    typedef struct packed {
        logic [NODE_W-1:0] max_in_node;
        logic [NODE_W-1:0] max_dst;
        logic [NODE_W-1:0] max_src;
        logic [MAXC_W-1:0] max_cost;
        logic [NODE_W-1:0] out_degree;
        logic [NODE_W-1:0] row_node;
    } out_fields_t;

    typedef struct packed {
        logic        last;
        out_fields_t fields;
    } result_t;

endpackage

// ===== design/adjacency_matrix_degree_scan_unit.sv =====
// channel   | direction | payload                                            | request
// s_axis    | in        | tdata: arc_cost                                    | one matrix entry
// m_axis    | out       | tdata: row_node..max_in_node, tlast: last          | one row result
// cfg       | in        | data: node_count                                   | register write
//
// one entry per cycle unless s_axis stalls; a row result passes the entry stage register
// into the result queue; the column-count memory read-modify-write sets that rate, with
// forwarding of the previous write and per-column valid bits that clear at once on each
// new matrix; reset restores node_count 64 and a fresh matrix; no clearing pass is needed
// s_axis stalls only when the four-entry result queue could overflow
module adjacency_matrix_degree_scan_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [amds_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // arc_cost
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // row_node, out_degree, max_cost, max_src, max_dst, max_in_node
    output logic [amds_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [amds_pkg::CFG_W-1:0]        cfg_data        // node_count
);

    import amds_pkg::*;

`include "adjacency_matrix_degree_scan_unit_assert.svh"

    // configuration and position
    logic [COL_W-1:0]     last_idx_reg, last_idx_next;
    logic [COL_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;

    // entry stage registers
    logic                 s1_valid_reg;
    logic [COL_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [COST_BITS-1:0] s1_cost_reg;
    logic                 s1_eor_reg;
    logic                 s1_eom_reg;

    // matrix accumulators
    logic [CNT_W-1:0]     row_nz_reg, row_nz_next;
    logic [COST_BITS-2:0] best_cost_reg, best_cost_next;
    logic [NODE_W-1:0]    best_src_reg, best_src_next;
    logic [NODE_W-1:0]    best_dst_reg, best_dst_next;
    logic [CNT_W-1:0]     best_in_cnt_reg, best_in_cnt_next;
    logic [COL_W-1:0]     best_in_node_reg, best_in_node_next;

    // column count validity and forwarding
    logic [MAX_NODES-1:0] valid_reg, valid_next;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [COL_W-1:0]     fwd_col_reg;
    logic [CNT_W-1:0]     fwd_cnt_reg;

    // result queue
    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]     occ_reg;

    logic                 in_accept;
    logic                 cfg_accept;
    logic                 s1_res;
    logic                 eor_in;
    logic                 eom_in;
    logic [CNT_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]     cnt_old;
    logic [CNT_W-1:0]     cnt_new;
    logic                 cost_nz;
    logic                 cost_pos;
    logic                 cnt_wr;
    logic                 fifo_wr;
    logic                 fifo_rd;
    result_t              res_new;
    result_t              fifo_head;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign in_accept  = s_axis_tvalid & s_axis_tready;

    // room for the pending result plus one more
    assign s1_res        = s1_valid_reg & s1_eor_reg;
    assign s_axis_tready = ({1'b0, occ_reg} + {{OCC_W{1'b0}}, s1_res})
                           < (OCC_W + 1)'(FIFO_DEPTH);

    // clamp of the node count on write
    always_comb
    begin
        last_idx_next = last_idx_reg;
        if (cfg_accept)
        begin
            if (cfg_data == '0)
            begin
                last_idx_next = '0;
            end
            else if (32'(cfg_data) > MAX_NODES)
            begin
                last_idx_next = COL_W'(MAX_NODES - 1);
            end
            else
            begin
                last_idx_next = COL_W'(cfg_data - CFG_W'(1));
            end
        end
    end

    // row and column position of the incoming entry
    assign eor_in = (col_reg == last_idx_reg);
    assign eom_in = eor_in && (row_reg == last_idx_reg);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_accept)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (in_accept)
        begin
            if (eom_in)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (eor_in)
            begin
                row_next = row_reg + COL_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // column count memory
    amds_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_NODES)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (cnt_wr),
        .wr_addr (s1_col_reg),
        .wr_data (cnt_new),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    // count read with forwarding of the previous write
    always_comb
    begin
        if (fwd_valid_reg && (fwd_col_reg == s1_col_reg))
        begin
            cnt_old = fwd_cnt_reg;
        end
        else if (valid_reg[s1_col_reg])
        begin
            cnt_old = ram_rdata;
        end
        else
        begin
            cnt_old = '0;
        end
    end

    assign cost_nz  = |s1_cost_reg;
    assign cost_pos = cost_nz & ~s1_cost_reg[COST_BITS-1];
    assign cnt_new  = cnt_old + CNT_W'(1);
    assign cnt_wr   = s1_valid_reg & cost_pos;

    // accumulator update for the entry in flight
    always_comb
    begin
        row_nz_next       = row_nz_reg;
        best_cost_next    = best_cost_reg;
        best_src_next     = best_src_reg;
        best_dst_next     = best_dst_reg;
        best_in_cnt_next  = best_in_cnt_reg;
        best_in_node_next = best_in_node_reg;
        valid_next        = valid_reg;
        fwd_valid_next    = fwd_valid_reg;
        if (s1_valid_reg)
        begin
            row_nz_next = row_nz_reg + CNT_W'(cost_nz);
            if (cost_pos)
            begin
                valid_next[s1_col_reg] = 1'b1;
                fwd_valid_next         = 1'b1;
                if ((cnt_new > best_in_cnt_reg) ||
                    ((cnt_new == best_in_cnt_reg) && (s1_col_reg < best_in_node_reg)))
                begin
                    best_in_cnt_next  = cnt_new;
                    best_in_node_next = s1_col_reg;
                end
                if (s1_cost_reg[COST_BITS-2:0] > best_cost_reg)
                begin
                    best_cost_next = s1_cost_reg[COST_BITS-2:0];
                    best_src_next  = NODE_W'(s1_row_reg) + NODE_W'(1);
                    best_dst_next  = NODE_W'(s1_col_reg) + NODE_W'(1);
                end
            end
        end
    end

    // result built from the updated accumulators
    always_comb
    begin
        res_new                    = '0;
        res_new.fields.row_node    = NODE_W'(s1_row_reg) + NODE_W'(1);
        res_new.fields.out_degree  = NODE_W'(row_nz_next);
        if (s1_eom_reg)
        begin
            res_new.last               = 1'b1;
            res_new.fields.max_cost    = MAXC_W'(best_cost_next);
            res_new.fields.max_src     = best_src_next;
            res_new.fields.max_dst     = best_dst_next;
            res_new.fields.max_in_node = NODE_W'(best_in_node_next) + NODE_W'(1);
        end
    end

    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg     <= COL_W'(MAX_NODES - 1);
            row_reg          <= '0;
            col_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            row_nz_reg       <= '0;
            best_cost_reg    <= '0;
            best_src_reg     <= '0;
            best_dst_reg     <= '0;
            best_in_cnt_reg  <= '0;
            best_in_node_reg <= '0;
            valid_reg        <= '0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            last_idx_reg <= last_idx_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= in_accept;
            if (cfg_accept || (s1_valid_reg && s1_eom_reg))
            begin
                row_nz_reg       <= '0;
                best_cost_reg    <= '0;
                best_src_reg     <= '0;
                best_dst_reg     <= '0;
                best_in_cnt_reg  <= '0;
                best_in_node_reg <= '0;
                valid_reg        <= '0;
                fwd_valid_reg    <= 1'b0;
            end
            else
            begin
                row_nz_reg       <= (s1_valid_reg && s1_eor_reg) ? '0 : row_nz_next;
                best_cost_reg    <= best_cost_next;
                best_src_reg     <= best_src_next;
                best_dst_reg     <= best_dst_next;
                best_in_cnt_reg  <= best_in_cnt_next;
                best_in_node_reg <= best_in_node_next;
                valid_reg        <= valid_next;
                fwd_valid_reg    <= fwd_valid_next;
            end
        end
    end

    // entry stage, forwarding payload and result queue storage
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_cost_reg <= s_axis_tdata[COST_BITS-1:0];
            s1_eor_reg  <= eor_in;
            s1_eom_reg  <= eom_in;
        end
        if (cnt_wr)
        begin
            fwd_col_reg <= s1_col_reg;
            fwd_cnt_reg <= cnt_new;
        end
        if (fifo_wr)
        begin
            fifo_reg[wr_ptr_reg] <= res_new;
        end
    end

    // result queue pointers
    assign fifo_wr = s1_res;
    assign fifo_rd = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (fifo_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_wr && !fifo_rd)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (fifo_rd && !fifo_wr)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

    // output side
    assign fifo_head     = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (occ_reg != '0);
    assign m_axis_tdata  = OUT_TDATA_W'(fifo_head.fields);
    assign m_axis_tlast  = fifo_head.last;

    // checks
    `AMDS_ASSERT_NOW(a_queue_no_overflow, clk, rst_n,
        fifo_wr && !fifo_rd, occ_reg != OCC_W'(FIFO_DEPTH))
    `AMDS_ASSERT_NOW(a_matrix_end_is_row_end, clk, rst_n,
        s1_valid_reg && s1_eom_reg, s1_eor_reg)
    `AMDS_ASSERT_NEXT(a_matrix_end_clears_counts, clk, rst_n,
        s1_valid_reg && s1_eom_reg, (valid_reg == '0) && !fwd_valid_reg)
    `AMDS_ASSERT_NEXT(a_row_result_queued, clk, rst_n,
        s1_res, occ_reg != '0)

endmodule

// ===== design/amds_ram.sv =====
module amds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
